// ----- rtl/sps_pkg.sv -----
package sps_pkg;

  typedef enum logic [1:0] {
    ACT_POLL  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_RESET = 2'd3
  } action_t;

  localparam int unsigned DelayW = 26;
  localparam int unsigned SprW   = 13;
  localparam int unsigned CntW   = 12;
  localparam int unsigned RevW   = 16;
  localparam int unsigned StampW = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_STEP_DELAY    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STEPS_PER_REV = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FORWARD_DIR   = 2'd2;

  localparam logic [DelayW-1:0] STEP_DELAY_RST    = 26'd0;
  localparam logic [SprW-1:0]   STEPS_PER_REV_RST = 13'd2048;
  localparam logic              FORWARD_DIR_RST   = 1'b1;

  typedef struct packed {
    logic [DelayW-1:0] step_delay_us;
    logic [SprW-1:0]   steps_per_rev;
    logic              forward_dir;
  } cfg_t;

  typedef struct packed {
    logic [3:0]             coil_pattern;
    logic                   stepped;
    logic                   running;
    logic signed [RevW-1:0] rotation_count;
    logic [1:0]             phase;
  } result_t;

  function automatic logic [3:0] coil_of(input logic [1:0] ph);
    logic [3:0] pat;
    case (ph)
      2'd0:    pat = 4'b1010;
      2'd1:    pat = 4'b0110;
      2'd2:    pat = 4'b0101;
      default: pat = 4'b1001;
    endcase
    return pat;
  endfunction

endpackage

// ----- rtl/sps_core.sv -----
module sps_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [1:0]          action,
  input  logic [31:0]         now_us,
  input  sps_pkg::cfg_t       cfg,
  output sps_pkg::result_t    res
);

  logic                        run_flag;
  logic                        run_flag_next;
  logic [1:0]                  phase_index;
  logic [1:0]                  phase_index_next;
  logic [sps_pkg::StampW-1:0]  last_step_stamp;
  logic [sps_pkg::StampW-1:0]  last_step_stamp_next;
  logic [sps_pkg::CntW-1:0]    steps_in_rev;
  logic [sps_pkg::CntW-1:0]    steps_in_rev_next;
  logic [sps_pkg::RevW-1:0]    revolutions;
  logic [sps_pkg::RevW-1:0]    revolutions_next;
  logic [3:0]                  coil_drive;
  logic [3:0]                  coil_drive_next;
  logic                        stepped_next;
  logic [sps_pkg::StampW-1:0]  elapsed;
  logic [sps_pkg::SprW-1:0]    step_cnt;
  sps_pkg::action_t            act;

  assign act      = sps_pkg::action_t'(action);
  assign elapsed  = now_us - last_step_stamp;
  assign step_cnt = {1'b0, steps_in_rev} + 13'd1;

  always_comb begin
    run_flag_next        = run_flag;
    phase_index_next     = phase_index;
    last_step_stamp_next = last_step_stamp;
    steps_in_rev_next    = steps_in_rev;
    revolutions_next     = revolutions;
    coil_drive_next      = coil_drive;
    stepped_next         = 1'b0;
    unique case (act)
      sps_pkg::ACT_POLL: begin
        if (run_flag && elapsed >= {6'd0, cfg.step_delay_us}) begin
          stepped_next         = 1'b1;
          coil_drive_next      = sps_pkg::coil_of(phase_index);
          last_step_stamp_next = now_us;
          if (step_cnt >= cfg.steps_per_rev) begin
            steps_in_rev_next = '0;
            revolutions_next  = cfg.forward_dir ? revolutions - 16'd1
                                                : revolutions + 16'd1;
          end else begin
            steps_in_rev_next = step_cnt[sps_pkg::CntW-1:0];
          end
          phase_index_next = cfg.forward_dir ? phase_index + 2'd1 : phase_index - 2'd1;
        end
      end
      sps_pkg::ACT_START: begin
        run_flag_next = 1'b1;
      end
      sps_pkg::ACT_STOP: begin
        run_flag_next   = 1'b0;
        coil_drive_next = 4'd0;
      end
      sps_pkg::ACT_RESET: begin
        revolutions_next  = '0;
        steps_in_rev_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_flag        <= 1'b0;
      phase_index     <= 2'd0;
      last_step_stamp <= '0;
      steps_in_rev    <= '0;
      revolutions     <= '0;
      coil_drive      <= 4'd0;
    end else if (accept) begin
      run_flag        <= run_flag_next;
      phase_index     <= phase_index_next;
      last_step_stamp <= last_step_stamp_next;
      steps_in_rev    <= steps_in_rev_next;
      revolutions     <= revolutions_next;
      coil_drive      <= coil_drive_next;
    end
  end

  always_comb begin
    res.coil_pattern   = coil_drive_next;
    res.stepped        = stepped_next;
    res.running        = run_flag_next;
    res.rotation_count = $signed(revolutions_next);
    res.phase          = phase_index_next;
  end

  a_step_needs_run: assert property (@(posedge clk) disable iff (rst)
    accept && stepped_next |-> run_flag && act == sps_pkg::ACT_POLL)
    else $error("step taken while stopped or on a non-poll action");

  a_step_moves_phase: assert property (@(posedge clk) disable iff (rst)
    accept && stepped_next |=>
      (phase_index == $past(phase_index) + 2'd1) ||
      (phase_index == $past(phase_index) - 2'd1))
    else $error("phase did not move by one place on a step");

  a_stop_releases: assert property (@(posedge clk) disable iff (rst)
    accept && act == sps_pkg::ACT_STOP |=> !run_flag && coil_drive == 4'd0)
    else $error("stop left the motor running or coils driven");

endmodule

// ----- rtl/stepper_phase_sequencer.sv -----
// Full-step sequencer for a four-coil stepper motor.
// Input channel (in_valid/in_ready) carries one transaction per command:
// an action (poll, start, stop, clear rotation counters) and a free-running
// microsecond timestamp. Every input transaction yields exactly one result
// transaction on the output channel (out_valid/out_ready): coil drive
// pattern, step flag, run flag, signed revolution count and next phase.
// A poll while running steps once the wrapped difference between the
// timestamp and the last step's stamp reaches step_delay_us.
// The result is registered: out_valid rises in the cycle after an input transaction is
// taken. One transaction is taken every cycle while the receiver does not stall, as the
// whole update is a single compare and a few counter adds between the state registers
// and the result register. A stalled receiver holds the result register; in_ready drops
// only while that register is full and not being taken. Reset: stopped, phase 0, coils
// low, counters and stamp zero, delay 0, 2048 steps per revolution, forward direction.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user must write it
// only while no transaction is pending, as the block itself does not enforce this.
module stepper_phase_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [25:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [31:0]        now_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         coil_pattern,
  output logic               stepped,
  output logic               running,
  output logic signed [15:0] rotation_count,
  output logic [1:0]         phase
);

  sps_pkg::cfg_t    cfg;
  sps_pkg::result_t res;
  sps_pkg::result_t res_q;
  logic             in_accept;

  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_delay_us <= sps_pkg::STEP_DELAY_RST;
      cfg.steps_per_rev <= sps_pkg::STEPS_PER_REV_RST;
      cfg.forward_dir   <= sps_pkg::FORWARD_DIR_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sps_pkg::CFG_STEP_DELAY:    cfg.step_delay_us <= cfg_data;
        sps_pkg::CFG_STEPS_PER_REV: cfg.steps_per_rev <= cfg_data[sps_pkg::SprW-1:0];
        sps_pkg::CFG_FORWARD_DIR:   cfg.forward_dir   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  sps_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (in_accept),
    .action (action),
    .now_us (now_us),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_q <= res;
    end
  end

  assign coil_pattern   = res_q.coil_pattern;
  assign stepped        = res_q.stepped;
  assign running        = res_q.running;
  assign rotation_count = res_q.rotation_count;
  assign phase          = res_q.phase;

  a_accept_to_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result register is stalled");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

// ----- sim/stepper_phase_sequencer_test.sv -----
module stepper_phase_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sps_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT      = 4000;
  localparam int unsigned HOLD_CYCLES      = 200;
  localparam int unsigned SHOWN_MISMATCHES = 10;
  localparam int unsigned RANDOM_PHASES    = 16;
  localparam int unsigned PHASE_ITEMS      = 100;

  typedef struct {
    bit                  is_reg;
    logic [CfgIdxW-1:0]  idx;
    logic [DelayW-1:0]   data;
    action_t             act;
    logic [StampW-1:0]   stamp;
    bit                  typed;
    result_t             res;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [25:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         action;
  logic [31:0]        now_us;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         coil_pattern;
  logic               stepped;
  logic               running;
  logic signed [15:0] rotation_count;
  logic [1:0]         phase;

  stepper_phase_sequencer dut (.*);

  // Motor model state and register copy
  logic [DelayW-1:0] cfg_delay;
  logic [SprW-1:0]   cfg_spr;
  logic              cfg_fwd;
  logic              run_q;
  logic [1:0]        phase_q;
  logic [StampW-1:0] stamp_q;
  logic [CntW-1:0]   count_q;
  logic [RevW-1:0]   revs_q;
  logic [3:0]        coils_q;

  result_t     due_outputs[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned src_gap_max;
  int unsigned sink_gap_max;
  int unsigned hold_request;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t predict_motor(action_t act, logic [StampW-1:0] stamp);
    logic [StampW-1:0] elapsed;
    logic [SprW-1:0]   next_count;
    result_t           r;
    r.stepped = 1'b0;
    elapsed = stamp - stamp_q;
    case (act)
      ACT_POLL: begin
        if (run_q && elapsed >= 32'(cfg_delay)) begin
          case (phase_q)
            2'd0:    coils_q = 4'b1010;
            2'd1:    coils_q = 4'b0110;
            2'd2:    coils_q = 4'b0101;
            default: coils_q = 4'b1001;
          endcase
          next_count = {1'b0, count_q} + 1'b1;
          if (next_count >= cfg_spr) begin
            revs_q = cfg_fwd ? revs_q - 1'b1 : revs_q + 1'b1;
            next_count = '0;
          end
          count_q = next_count[CntW-1:0];
          stamp_q = stamp;
          phase_q = cfg_fwd ? phase_q + 1'b1 : phase_q - 1'b1;
          r.stepped = 1'b1;
        end
      end
      ACT_START: run_q = 1'b1;
      ACT_STOP: begin
        run_q = 1'b0;
        coils_q = 4'b0000;
      end
      default: begin
        revs_q = '0;
        count_q = '0;
      end
    endcase
    r.coil_pattern = coils_q;
    r.running = run_q;
    r.rotation_count = revs_q;
    r.phase = phase_q;
    return r;
  endfunction

  function automatic result_t outputs_of(logic [3:0] coils, logic st, logic run,
                                         logic [RevW-1:0] revs, logic [1:0] ph);
    result_t r;
    r.coil_pattern = coils;
    r.stepped = st;
    r.running = run;
    r.rotation_count = revs;
    r.phase = ph;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [DelayW-1:0] data);
    plan_row_t row;
    row.is_reg = 1'b1;
    row.idx = idx;
    row.data = data;
    row.act = ACT_POLL;
    row.stamp = '0;
    row.typed = 1'b0;
    row.res = '0;
    return row;
  endfunction

  function automatic plan_row_t item_row(action_t act, logic [StampW-1:0] stamp);
    plan_row_t row;
    row = reg_row(CFG_STEP_DELAY, '0);
    row.is_reg = 1'b0;
    row.act = act;
    row.stamp = stamp;
    return row;
  endfunction

  function automatic plan_row_t checked_row(action_t act, logic [StampW-1:0] stamp,
                                            result_t res);
    plan_row_t row;
    row = item_row(act, stamp);
    row.typed = 1'b1;
    row.res = res;
    return row;
  endfunction

  task automatic send_item(action_t act, logic [StampW-1:0] stamp, bit typed,
                           result_t typed_res);
    int unsigned gap;
    result_t     predicted;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    now_us <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_motor(act, stamp);
    due_outputs.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DelayW-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    case (idx)
      CFG_STEP_DELAY:    cfg_delay = data;
      CFG_STEPS_PER_REV: cfg_spr = data[SprW-1:0];
      CFG_FORWARD_DIR:   cfg_fwd = data[0];
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (due_outputs.size() != 0);
  endtask

  initial begin
    plan_row_t         plan[$];
    logic [StampW-1:0] now_cur;
    logic [DelayW-1:0] delay_pick;
    logic [SprW-1:0]   spr_pick;
    logic [SprW-1:0]   burst_spr[3];
    int unsigned       burst_len[3];
    int unsigned       span;
    int unsigned       pick;
    action_t           act;

    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    action = ACT_POLL;
    now_us = '0;
    src_gap_max = 10;
    sink_gap_max = 10;
    hold_request = 0;
    mismatches = 0;
    cfg_delay = STEP_DELAY_RST;
    cfg_spr = STEPS_PER_REV_RST;
    cfg_fwd = FORWARD_DIR_RST;
    run_q = 1'b0;
    phase_q = '0;
    stamp_q = '0;
    count_q = '0;
    revs_q = '0;
    coils_q = '0;
    burst_spr = '{13'd0, 13'd8191, 13'd4096};
    burst_len = '{8, 8, 8};

    plan.push_back(checked_row(ACT_POLL, 32'd0,
                               outputs_of(4'h0, 1'b0, 1'b0, 16'd0, 2'd0)));
    plan.push_back(checked_row(ACT_START, 32'd5,
                               outputs_of(4'h0, 1'b0, 1'b1, 16'd0, 2'd0)));
    plan.push_back(checked_row(ACT_POLL, 32'd0,
                               outputs_of(4'hA, 1'b1, 1'b1, 16'd0, 2'd1)));
    plan.push_back(checked_row(ACT_POLL, 32'hFFFF_FFFF,
                               outputs_of(4'h6, 1'b1, 1'b1, 16'd0, 2'd2)));
    plan.push_back(checked_row(ACT_START, 32'h1234_5678,
                               outputs_of(4'h6, 1'b0, 1'b1, 16'd0, 2'd2)));
    plan.push_back(checked_row(ACT_STOP, 32'd0,
                               outputs_of(4'h0, 1'b0, 1'b0, 16'd0, 2'd2)));
    plan.push_back(checked_row(ACT_POLL, 32'd0,
                               outputs_of(4'h0, 1'b0, 1'b0, 16'd0, 2'd2)));
    plan.push_back(item_row(ACT_START, 32'd0));
    plan.push_back(item_row(ACT_RESET, 32'd0));
    plan.push_back(item_row(ACT_POLL, 32'd100));
    plan.push_back(item_row(ACT_POLL, 32'd200));
    plan.push_back(item_row(ACT_POLL, 32'd300));
    plan.push_back(reg_row(CFG_STEPS_PER_REV, 26'd2));
    plan.push_back(item_row(ACT_POLL, 32'd400));
    plan.push_back(item_row(ACT_RESET, 32'd400));
    plan.push_back(reg_row(CFG_STEPS_PER_REV, 26'd0));
    plan.push_back(reg_row(CFG_FORWARD_DIR, 26'd0));
    plan.push_back(item_row(ACT_POLL, 32'd500));
    plan.push_back(item_row(ACT_POLL, 32'd600));
    plan.push_back(reg_row(CFG_STEP_DELAY, 26'h3FF_FFFF));
    plan.push_back(item_row(ACT_POLL, 32'h0400_0256));
    plan.push_back(item_row(ACT_POLL, 32'h0400_0257));
    plan.push_back(item_row(ACT_POLL, 32'hFFFF_FFF0));
    plan.push_back(item_row(ACT_POLL, 32'h03FF_FFEF));
    plan.push_back(item_row(ACT_POLL, 32'h03FF_FFF0));
    plan.push_back(reg_row(CFG_UNUSED, 26'h2AA_AAAA));
    plan.push_back(item_row(ACT_STOP, 32'd0));
    plan.push_back(item_row(ACT_RESET, 32'hFFFF_FFFF));

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        wait_drained();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].act, plan[i].stamp, plan[i].typed, plan[i].res);
      end
    end

    // Short zero-delay runs: a revolution per step, then wide step counts
    now_cur = 32'hFFFF_FFF8;
    for (int b = 0; b < 3; b++) begin
      wait_drained();
      src_gap_max = 0;
      sink_gap_max = 0;
      write_reg(CFG_STEP_DELAY, 26'd0);
      write_reg(CFG_STEPS_PER_REV, 26'(burst_spr[b]));
      write_reg(CFG_FORWARD_DIR, 26'd1);
      send_item(ACT_START, now_cur, 1'b0, '0);
      send_item(ACT_RESET, now_cur, 1'b0, '0);
      for (int k = 0; k < burst_len[b]; k++) begin
        send_item(ACT_POLL, now_cur, 1'b0, '0);
        now_cur = now_cur + 1'b1;
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case ($urandom_range(0, 5))
        0:       delay_pick = '0;
        1:       delay_pick = '1;
        2, 3:    delay_pick = 26'($urandom_range(1, 20));
        4:       delay_pick = 26'($urandom_range(20, 300));
        default: delay_pick = 26'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       spr_pick = '0;
        1:       spr_pick = 13'd8191;
        2, 3:    spr_pick = 13'($urandom_range(1, 8));
        default: spr_pick = 13'($urandom_range(0, 8191));
      endcase
      write_reg(CFG_STEP_DELAY, delay_pick);
      write_reg(CFG_STEPS_PER_REV, {13'($urandom), spr_pick});
      write_reg(CFG_FORWARD_DIR, {25'($urandom), 1'($urandom)});
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, 26'($urandom));
      src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      // Stall the output while the input keeps offering
      if (p == 3) begin
        src_gap_max = 0;
        hold_request = HOLD_CYCLES;
      end
      span = 2 * int'(cfg_delay) + 2;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 7 && k == PHASE_ITEMS / 2) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 72) act = ACT_POLL;
        else if (pick < 84) act = ACT_START;
        else if (pick < 92) act = ACT_STOP;
        else act = ACT_RESET;
        case ($urandom_range(0, 9))
          0:             now_cur = $urandom;
          1, 2, 3, 4, 5, 6: now_cur = now_cur + $urandom_range(0, span);
          default:       now_cur = now_cur + $urandom_range(0, 3);
        endcase
        send_item(act, now_cur, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (4) @(negedge clk);
    if (due_outputs.size() != 0) begin
      mismatches += due_outputs.size();
      $display("%0d expected transactions never arrived", due_outputs.size());
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int unsigned hold;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      hold = hold_request + $urandom_range(0, sink_gap_max);
      hold_request = 0;
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_outputs
    result_t want;
    result_t got;
    if (!rst && out_valid && out_ready) begin
      got.coil_pattern = coil_pattern;
      got.stepped = stepped;
      got.running = running;
      got.rotation_count = rotation_count;
      got.phase = phase;
      if (due_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("%0t: unexpected transaction coil=%h stepped=%b running=%b rot=%0d phase=%0d",
                   $realtime, got.coil_pattern, got.stepped, got.running,
                   got.rotation_count, got.phase);
      end else begin
        want = due_outputs.pop_front();
        if (got.coil_pattern !== want.coil_pattern || got.stepped !== want.stepped ||
            got.running !== want.running || got.rotation_count !== want.rotation_count ||
            got.phase !== want.phase) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("%0t: expected coil=%h stepped=%b running=%b rot=%0d phase=%0d, %s",
                     $realtime, want.coil_pattern, want.stepped, want.running,
                     want.rotation_count, want.phase,
                     $sformatf("got coil=%h stepped=%b running=%b rot=%0d phase=%0d",
                               got.coil_pattern, got.stepped, got.running,
                               got.rotation_count, got.phase));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- files.f -----
rtl/sps_pkg.sv
rtl/sps_core.sv
rtl/stepper_phase_sequencer.sv
sim/stepper_phase_sequencer_test.sv
